[design/ptd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_pkg: shared constants and types for the trial-division prime tester
// Word widths, the divisor width and the status bundle of the divider.
// ----------------------------------------------------------------------------
package ptd_pkg;

  // Width of the tested word (two's complement)
  localparam int DATA_WIDTH = 32;
  // Magnitude bits of a non-negative word
  localparam int MAG_W      = DATA_WIDTH - 1;
  // Trial divisor width: covers sqrt of the largest word plus the wheel step
  localparam int DIV_W      = DATA_WIDTH / 2 + 1;
  // Width of the squared divisor
  localparam int SQ_W       = 2 * DIV_W;
  // Bit counter of the divider
  localparam int CNT_W      = $clog2(MAG_W);

  // Divider status towards the sequencer
  typedef struct packed {
    logic done;      // one-cycle pulse, remainder is final
    logic rem_zero;  // divisor divides the dividend exactly
  } div_stat_t;

endpackage

`default_nettype wire

[design/ptd_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_div: bit-serial restoring remainder unit
// Takes one dividend bit per cycle and reports whether the remainder is zero.
// ----------------------------------------------------------------------------
module ptd_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [ptd_pkg::MAG_W-1:0]     dividend,
  input  wire logic [ptd_pkg::DIV_W-1:0]     divisor,
  output ptd_pkg::div_stat_t                 stat
);

  logic                          busy;
  logic                          done;
  logic [ptd_pkg::CNT_W-1:0]     cnt;
  logic [ptd_pkg::MAG_W-1:0]     dvd;
  logic [ptd_pkg::DIV_W-1:0]     dsr;
  logic [ptd_pkg::DIV_W-1:0]     rem;

  logic [ptd_pkg::DIV_W:0]       rem_sh;
  logic [ptd_pkg::DIV_W:0]       diff;
  logic [ptd_pkg::DIV_W-1:0]     rem_next;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    rem_sh   = {rem, dvd[ptd_pkg::MAG_W-1]};
    diff     = rem_sh - {1'b0, dsr};
    rem_next = diff[ptd_pkg::DIV_W] ? rem_sh[ptd_pkg::DIV_W-1:0]
                                    : diff[ptd_pkg::DIV_W-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ptd_pkg::CNT_W'(ptd_pkg::MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[ptd_pkg::MAG_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign stat.done     = done;
  assign stat.rem_zero = (rem == '0);

endmodule

`default_nettype wire

[design/prime_test_trial_division.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prime_test_trial_division: primality test by 6k+/-1 trial division
// Sequencer around one bit-serial remainder unit and one squarer.
// ----------------------------------------------------------------------------
// One number is tested at a time; in_ready is high only while the sequencer
// is idle. Negative values, 0 and 1 give a result straight from the
// classification, as do 2, 3 and even values; other values first take a
// division by 3, then each wheel step (divisors d and d+2) costs two serial
// divisions, for about floor(sqrt(n))/6 steps. The serial remainder unit, one
// dividend bit per cycle, sets the run time of a test. A finished result sits
// in an output register, so the next number can be transferred while it waits.
// ----------------------------------------------------------------------------
module prime_test_trial_division (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [ptd_pkg::DATA_WIDTH-1:0]  number,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic                                        is_prime,
  output logic signed [ptd_pkg::DATA_WIDTH-1:0]       kept_value
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLASS = 3'd1;
  localparam logic [2:0] S_WAIT3 = 3'd2;
  localparam logic [2:0] S_SQ    = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_WAITA = 3'd5;
  localparam logic [2:0] S_WAITB = 3'd6;
  localparam logic [2:0] S_RES   = 3'd7;

  logic [2:0]                           state;
  logic [ptd_pkg::DATA_WIDTH-1:0]       num;
  logic [ptd_pkg::DIV_W-1:0]            d;
  logic [ptd_pkg::SQ_W-1:0]             sq;
  logic                                 verdict;

  logic                                 div_start;
  logic [ptd_pkg::DIV_W-1:0]            div_dsr;
  ptd_pkg::div_stat_t                   div_stat;

  logic [ptd_pkg::MAG_W-1:0]            mag;
  logic                                 neg;

  assign mag      = num[ptd_pkg::MAG_W-1:0];
  assign neg      = num[ptd_pkg::DATA_WIDTH-1];
  assign in_ready = (state == S_IDLE);

  // Shared remainder unit
  ptd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (div_dsr),
    .stat     (div_stat)
  );

  // Divider launch: by 3 from classification, by d from compare, d+2 after
  always_comb begin
    div_start = 1'b0;
    div_dsr   = d;
    case (state)
      S_CLASS: begin
        div_dsr   = ptd_pkg::DIV_W'(3);
        div_start = !(neg || mag <= ptd_pkg::MAG_W'(3) || !mag[0]);
      end
      S_CMP: begin
        div_start = (sq <= {{(ptd_pkg::SQ_W-ptd_pkg::MAG_W){1'b0}}, mag});
      end
      S_WAITA: begin
        div_dsr   = d + ptd_pkg::DIV_W'(2);
        div_start = div_stat.done && !div_stat.rem_zero;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CLASS;
          end
        end
        S_CLASS: begin
          if (neg || mag <= ptd_pkg::MAG_W'(1)) begin
            verdict <= 1'b0;
            state   <= S_RES;
          end else if (mag <= ptd_pkg::MAG_W'(3)) begin
            verdict <= 1'b1;
            state   <= S_RES;
          end else if (!mag[0]) begin
            verdict <= 1'b0;
            state   <= S_RES;
          end else begin
            state <= S_WAIT3;
          end
        end
        S_WAIT3: begin
          if (div_stat.done) begin
            if (div_stat.rem_zero) begin
              verdict <= 1'b0;
              state   <= S_RES;
            end else begin
              d     <= ptd_pkg::DIV_W'(5);
              state <= S_SQ;
            end
          end
        end
        S_SQ: begin
          sq    <= {{ptd_pkg::DIV_W{1'b0}}, d} * {{ptd_pkg::DIV_W{1'b0}}, d};
          state <= S_CMP;
        end
        S_CMP: begin
          if (div_start) begin
            state <= S_WAITA;
          end else begin
            verdict <= 1'b1;
            state   <= S_RES;
          end
        end
        S_WAITA: begin
          if (div_stat.done) begin
            if (div_stat.rem_zero) begin
              verdict <= 1'b0;
              state   <= S_RES;
            end else begin
              state <= S_WAITB;
            end
          end
        end
        S_WAITB: begin
          if (div_stat.done) begin
            if (div_stat.rem_zero) begin
              verdict <= 1'b0;
              state   <= S_RES;
            end else begin
              d     <= d + ptd_pkg::DIV_W'(6);
              state <= S_SQ;
            end
          end
        end
        S_RES: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result valid: set when a verdict is loaded, cleared on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RES && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Input capture and result register
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      num <= number;
    end
    if (state == S_RES && (!out_valid || out_ready)) begin
      is_prime   <= verdict;
      kept_value <= verdict ? num : '0;
    end
  end

endmodule

`default_nettype wire
